@@ sv/rgbfsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB Floyd-Steinberg dither: shared definitions
// Widths, register indices, share weights and the error arithmetic helpers.
// ----------------------------------------------------------------------------
package rgbfsd_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int CNT_W     = ADDR_W + 1;

    localparam int NUM_CH    = 3;
    localparam int PIX_W     = 8;
    localparam int STEP_W    = 8;
    localparam int LW_W      = 12;
    localparam int TDATA_W   = NUM_CH * PIX_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LW_W;

    localparam int ERR_W     = 20;
    localparam int LB_W      = NUM_CH * ERR_W;
    localparam int V_W       = 22;
    localparam int D_W       = V_W + 2;
    localparam int DIV_W     = V_W - 8;
    localparam int Q_W       = DIV_W + 1;
    localparam int PROD_W    = DIV_W + STEP_W + 2;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int CMP_W     = ((LW_W > CNT_W) ? LW_W : CNT_W) + 1;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
    localparam logic [CMP_W-1:0]     WIDTH_MAX_C = CMP_W'(MAX_WIDTH);

    localparam logic [CFG_IDX_W-1:0] REG_STEP_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_BLUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd3;

    localparam logic [STEP_W-1:0] STEP_RESET  = 8'd255;
    localparam logic [LW_W-1:0]   WIDTH_RESET = 12'd1024;

    localparam logic [3:0] SHARE_RIGHT       = 4'd7;
    localparam logic [3:0] SHARE_BELOW       = 4'd5;
    localparam logic [3:0] SHARE_BELOW_LEFT  = 4'd3;
    localparam logic [3:0] SHARE_BELOW_RIGHT = 4'd1;

    localparam logic signed [D_W-1:0] ERR_MAX_D = D_W'((2 ** (ERR_W - 1)) - 1);
    localparam logic signed [D_W-1:0] ERR_MIN_D = -ERR_MAX_D - D_W'(1);

    function automatic logic signed [D_W-1:0] ext_err(input logic signed [ERR_W-1:0] e);
        return {{(D_W - ERR_W){e[ERR_W-1]}}, e};
    endfunction

    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [D_W-1:0] v);
        logic signed [ERR_W-1:0] res;
        if (v > ERR_MAX_D) begin
            res = ERR_MAX_D[ERR_W-1:0];
        end else if (v < ERR_MIN_D) begin
            res = ERR_MIN_D[ERR_W-1:0];
        end else begin
            res = v[ERR_W-1:0];
        end
        return res;
    endfunction

    // floor(e * k / 16): the arithmetic shift rounds toward minus infinity.
    function automatic logic signed [ERR_W-1:0] share(input logic signed [ERR_W-1:0] e,
                                                     input logic [3:0] k);
        logic signed [D_W-1:0] p;
        p = ext_err(e) * $signed({1'b0, k});
        return p[ERR_W+3:4];
    endfunction

    // One restoring division step: returns the quotient bit above the new remainder.
    function automatic logic [STEP_W:0] div_step(input logic [STEP_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [STEP_W-1:0] d);
        logic [STEP_W:0] trial;
        logic [STEP_W:0] diff;
        logic [STEP_W:0] res;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            res = {1'b1, diff[STEP_W-1:0]};
        end else begin
            res = {1'b0, trial[STEP_W-1:0]};
        end
        return res;
    endfunction

endpackage

@@ sv/rgbfsd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rgbfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rgb_floyd_steinberg_dither.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB Floyd-Steinberg error-diffusion dither
// Quantises each channel of a raster-order RGB stream to its configured step
// and spreads the error to the right neighbour and to the row below.
// ----------------------------------------------------------------------------
// From transfer in to result ready a pixel passes these states: S_IDLE
// accepts it and addresses the line buffer, S_LOAD takes the read data,
// S_PREP prepares the dividend, S_DIV runs the divider (two quotient bits per
// cycle, one lane per channel), S_POST requantises, and S_WR1 and S_WR2 write
// the below-row errors back; the divider and the single line buffer write
// port set the sequence length. The result sits in an output register, so the
// next pixel is accepted while it waits; the final step only holds if the
// previous result has still not been taken. The line buffer needs no clearing
// pass after reset: a fill count marks the columns written so far and the
// rest read as zero. Setting the frame-start flag in tuser clears the carried errors.
module rgb_floyd_steinberg_dither (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rgbfsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rgbfsd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rgbfsd_pkg::TDATA_W-1:0]     s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                               s_axis_tuser,  // frame_start
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rgbfsd_pkg::TDATA_W-1:0]     m_axis_tdata   // red_out, green_out, blue_out
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_PREP = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_POST = 7'b0010000,
        S_WR1  = 7'b0100000,
        S_WR2  = 7'b1000000
    } t_state;

    t_state r_state;

    logic [rgbfsd_pkg::STEP_W-1:0]       r_step     [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::STEP_W-1:0]       eff_step   [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::LW_W-1:0]         r_line_width;
    logic [rgbfsd_pkg::PIX_W-1:0]        r_pix      [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::ADDR_W-1:0]       r_col;
    logic [rgbfsd_pkg::ADDR_W-1:0]       r_x;
    logic                                r_first_row;
    logic [rgbfsd_pkg::CNT_W-1:0]        r_fill;
    logic signed [rgbfsd_pkg::ERR_W-1:0] r_carry    [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::ERR_W-1:0] r_pend     [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::ERR_W-1:0] r_prev_below [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::ERR_W-1:0] r_e        [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::V_W-1:0]   r_v        [rgbfsd_pkg::NUM_CH];
    logic                                r_neg      [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::DIV_W-1:0]        r_dvd      [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::DIV_W-1:0]        r_quo      [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::STEP_W-1:0]       r_rem      [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::DIV_CNT_W-1:0]    r_div_cnt;
    logic [rgbfsd_pkg::PIX_W-1:0]        r_out      [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::TDATA_W-1:0]      r_m_data;
    logic                                r_m_valid;

    logic signed [rgbfsd_pkg::ERR_W-1:0] above      [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::V_W-1:0]   v_next     [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::V_W-1:0]   abs_v      [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::V_W-1:0]          dvd_sum    [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::STEP_W:0]         div_a      [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::STEP_W:0]         div_b      [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::Q_W-1:0]   n_val      [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::PROD_W-1:0] prod      [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::Q_W-1:0]   q_val      [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::D_W-1:0]   diff       [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::ERR_W-1:0] e_next     [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::PIX_W-1:0]        out_next   [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::ERR_W-1:0] s_right    [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::ERR_W-1:0] s_below_rt [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::ERR_W-1:0] below_left [rgbfsd_pkg::NUM_CH];
    logic signed [rgbfsd_pkg::ERR_W-1:0] below_here [rgbfsd_pkg::NUM_CH];

    logic                              use_above;
    logic                              in_xfer;
    logic                              out_free;
    logic                              wr2_done;
    logic                              row_end;
    logic [rgbfsd_pkg::CMP_W-1:0]      width_ext;
    logic [rgbfsd_pkg::CMP_W-1:0]      width_eff;
    logic [rgbfsd_pkg::CMP_W-1:0]      col_p1;
    logic [rgbfsd_pkg::CNT_W-1:0]      x_ext;
    logic [rgbfsd_pkg::TDATA_W-1:0]    m_data_next;

    logic                              ram_we;
    logic [rgbfsd_pkg::ADDR_W-1:0]     ram_waddr;
    logic [rgbfsd_pkg::ADDR_W-1:0]     ram_raddr;
    logic [rgbfsd_pkg::LB_W-1:0]       ram_wdata;
    logic [rgbfsd_pkg::LB_W-1:0]       ram_rdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && (r_state == S_IDLE);
    assign out_free      = !r_m_valid || m_axis_tready;
    assign wr2_done      = (r_state == S_WR2) && out_free;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign x_ext     = {1'b0, r_x};
    assign use_above = !r_first_row && (x_ext < r_fill);

    assign width_ext = {{(rgbfsd_pkg::CMP_W - rgbfsd_pkg::LW_W){1'b0}}, r_line_width};
    assign col_p1    = {{(rgbfsd_pkg::CMP_W - rgbfsd_pkg::CNT_W){1'b0}}, x_ext}
                       + {{(rgbfsd_pkg::CMP_W - 1){1'b0}}, 1'b1};
    assign row_end   = (col_p1 >= width_eff);

    always_comb begin
        if (width_ext == '0) begin
            width_eff = {{(rgbfsd_pkg::CMP_W - 1){1'b0}}, 1'b1};
        end else if (width_ext > rgbfsd_pkg::WIDTH_MAX_C) begin
            width_eff = rgbfsd_pkg::WIDTH_MAX_C;
        end else begin
            width_eff = width_ext;
        end
    end

    always_comb begin
        m_data_next = '0;
        for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
            eff_step[c] = (r_step[c] == '0) ? {{(rgbfsd_pkg::STEP_W - 1){1'b0}}, 1'b1}
                                             : r_step[c];

            above[c]  = use_above ? $signed(ram_rdata[c*rgbfsd_pkg::ERR_W +: rgbfsd_pkg::ERR_W])
                                  : '0;
            v_next[c] = $signed({{(rgbfsd_pkg::V_W - rgbfsd_pkg::PIX_W - 8){1'b0}},
                                 r_pix[c], 8'b0})
                        + $signed({{(rgbfsd_pkg::V_W - rgbfsd_pkg::ERR_W){r_carry[c][rgbfsd_pkg::ERR_W-1]}},
                                   r_carry[c]})
                        + $signed({{(rgbfsd_pkg::V_W - rgbfsd_pkg::ERR_W){above[c][rgbfsd_pkg::ERR_W-1]}},
                                   above[c]});

            // Round half away from zero: |v| + step/2 in units of 1/256.
            abs_v[c]   = r_neg[c] ? -r_v[c] : r_v[c];
            dvd_sum[c] = $unsigned(abs_v[c])
                         + {{(rgbfsd_pkg::V_W - rgbfsd_pkg::STEP_W - 7){1'b0}}, eff_step[c], 7'b0};

            div_a[c] = rgbfsd_pkg::div_step(r_rem[c], r_dvd[c][rgbfsd_pkg::DIV_W-1], eff_step[c]);
            div_b[c] = rgbfsd_pkg::div_step(div_a[c][rgbfsd_pkg::STEP_W-1:0],
                                            r_dvd[c][rgbfsd_pkg::DIV_W-2], eff_step[c]);

            n_val[c] = r_neg[c] ? -$signed({1'b0, r_quo[c]}) : $signed({1'b0, r_quo[c]});
            prod[c]  = n_val[c] * $signed({1'b0, eff_step[c]});
            q_val[c] = prod[c][rgbfsd_pkg::Q_W-1:0];
            diff[c]  = $signed({{2{r_v[c][rgbfsd_pkg::V_W-1]}}, r_v[c]})
                       - $signed({{(rgbfsd_pkg::D_W - rgbfsd_pkg::Q_W - 8){q_val[c][rgbfsd_pkg::Q_W-1]}},
                                  q_val[c], 8'b0});
            e_next[c] = rgbfsd_pkg::sat_err(diff[c]);
            if (q_val[c] < 0) begin
                out_next[c] = '0;
            end else if (q_val[c] > 255) begin
                out_next[c] = '1;
            end else begin
                out_next[c] = q_val[c][rgbfsd_pkg::PIX_W-1:0];
            end

            s_right[c]    = rgbfsd_pkg::share(r_e[c], rgbfsd_pkg::SHARE_RIGHT);
            s_below_rt[c] = rgbfsd_pkg::share(r_e[c], rgbfsd_pkg::SHARE_BELOW_RIGHT);
            below_left[c] = rgbfsd_pkg::sat_err(rgbfsd_pkg::ext_err(r_prev_below[c])
                            + rgbfsd_pkg::ext_err(rgbfsd_pkg::share(r_e[c],
                                                  rgbfsd_pkg::SHARE_BELOW_LEFT)));
            below_here[c] = rgbfsd_pkg::sat_err(rgbfsd_pkg::ext_err(r_pend[c])
                            + rgbfsd_pkg::ext_err(rgbfsd_pkg::share(r_e[c],
                                                  rgbfsd_pkg::SHARE_BELOW)));

            m_data_next[c*rgbfsd_pkg::PIX_W +: rgbfsd_pkg::PIX_W] = r_out[c];
        end
    end

    always_comb begin
        ram_wdata = '0;
        for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
            ram_wdata[c*rgbfsd_pkg::ERR_W +: rgbfsd_pkg::ERR_W] =
                (r_state == S_WR1) ? below_left[c] : r_prev_below[c];
        end
    end

    assign ram_we    = ((r_state == S_WR1) && (r_x != '0)) || wr2_done;
    assign ram_waddr = (r_state == S_WR1) ? (r_x - {{(rgbfsd_pkg::ADDR_W - 1){1'b0}}, 1'b1})
                                          : r_x;
    assign ram_raddr = s_axis_tuser ? '0 : r_col;

    rgbfsd_ram #(
        .WIDTH (rgbfsd_pkg::LB_W),
        .DEPTH (rgbfsd_pkg::MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_line_width <= rgbfsd_pkg::WIDTH_RESET;
            r_col        <= '0;
            r_first_row  <= 1'b1;
            r_fill       <= '0;
            r_div_cnt    <= '0;
            r_m_valid    <= 1'b0;
            for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
                r_step[c]  <= rgbfsd_pkg::STEP_RESET;
                r_carry[c] <= '0;
                r_pend[c]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rgbfsd_pkg::REG_STEP_RED: begin
                        r_step[0] <= i_cfg_data[rgbfsd_pkg::STEP_W-1:0];
                    end
                    rgbfsd_pkg::REG_STEP_GREEN: begin
                        r_step[1] <= i_cfg_data[rgbfsd_pkg::STEP_W-1:0];
                    end
                    rgbfsd_pkg::REG_STEP_BLUE: begin
                        r_step[2] <= i_cfg_data[rgbfsd_pkg::STEP_W-1:0];
                    end
                    rgbfsd_pkg::REG_LINE_WIDTH: begin
                        r_line_width <= i_cfg_data[rgbfsd_pkg::LW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (wr2_done) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser) begin
                            r_col       <= '0;
                            r_first_row <= 1'b1;
                            for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
                                r_carry[c] <= '0;
                                r_pend[c]  <= '0;
                            end
                        end
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_div_cnt <= rgbfsd_pkg::DIV_LAST;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    if (r_div_cnt == '0) begin
                        r_state <= S_POST;
                    end else begin
                        r_div_cnt <= r_div_cnt - {{(rgbfsd_pkg::DIV_CNT_W - 1){1'b0}}, 1'b1};
                    end
                end
                S_POST: begin
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
                        r_carry[c] <= s_right[c];
                        r_pend[c]  <= s_below_rt[c];
                    end
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    if (out_free) begin
                        if (x_ext == r_fill) begin
                            r_fill <= x_ext + {{(rgbfsd_pkg::CNT_W - 1){1'b0}}, 1'b1};
                        end
                        if (row_end) begin
                            r_col       <= '0;
                            r_first_row <= 1'b0;
                            for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
                                r_carry[c] <= '0;
                                r_pend[c]  <= '0;
                            end
                        end else begin
                            r_col <= col_p1[rgbfsd_pkg::ADDR_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= s_axis_tuser ? '0 : r_col;
            for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
                r_pix[c] <= s_axis_tdata[c*rgbfsd_pkg::PIX_W +: rgbfsd_pkg::PIX_W];
            end
        end
        for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
            if (r_state == S_LOAD) begin
                r_v[c]   <= v_next[c];
                r_neg[c] <= v_next[c][rgbfsd_pkg::V_W-1];
            end
            if (r_state == S_PREP) begin
                r_dvd[c] <= dvd_sum[c][rgbfsd_pkg::V_W-1:8];
                r_quo[c] <= '0;
                r_rem[c] <= '0;
            end
            if (r_state == S_DIV) begin
                r_dvd[c] <= {r_dvd[c][rgbfsd_pkg::DIV_W-3:0], 2'b00};
                r_quo[c] <= {r_quo[c][rgbfsd_pkg::DIV_W-3:0],
                             div_a[c][rgbfsd_pkg::STEP_W], div_b[c][rgbfsd_pkg::STEP_W]};
                r_rem[c] <= div_b[c][rgbfsd_pkg::STEP_W-1:0];
            end
            if (r_state == S_POST) begin
                r_e[c]   <= e_next[c];
                r_out[c] <= out_next[c];
            end
            if (r_state == S_WR1) begin
                r_prev_below[c] <= below_here[c];
            end
        end
        if (wr2_done) begin
            r_m_data <= m_data_next;
        end
    end

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_LOAD))
        else $error("accepted pixel did not start a line buffer read");

    a_fill_covers_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill >= {1'b0, r_col})
        else $error("column ahead of the written part of the line buffer");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (((r_state == S_WR1) && (r_x != '0)) || (r_state == S_WR2)))
        else $error("line buffer written outside the write-back steps");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr2_done |=> (r_m_valid && (r_state == S_IDLE)))
        else $error("finished pixel did not reach the output register");

endmodule

@@ dv/tb_rgb_floyd_steinberg_dither.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the RGB Floyd-Steinberg error-diffusion dither
// A short table of directed pixels runs first, under the reset settings. A
// sweep of step and line width settings follows, then random phases. Known
// table rows are checked against their table values and every other result
// against a local model of the quantiser and of its carried errors. Both stream sides pause at random.
// ----------------------------------------------------------------------------
module tb_rgb_floyd_steinberg_dither;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PLAN_N      = 16;
    localparam int RANDOM_ITEMS = 690;

    // tdata order from the lowest bit up: red, green, blue.
    typedef struct packed {
        logic [rgbfsd_pkg::PIX_W-1:0] blue;
        logic [rgbfsd_pkg::PIX_W-1:0] green;
        logic [rgbfsd_pkg::PIX_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic fs;
        logic known;
        t_rgb px;
        t_rgb want;
    } t_plan_row;

    // Rows marked known have every carried error at zero, so 0 and 255 pass
    // through unchanged.
    localparam t_plan_row PLAN [PLAN_N] = '{
        '{1'b1, 1'b1, 24'h000000, 24'h000000},
        '{1'b0, 1'b1, 24'hFFFFFF, 24'hFFFFFF},
        '{1'b0, 1'b1, 24'h00FF00, 24'h00FF00},
        '{1'b0, 1'b1, 24'hFF00FF, 24'hFF00FF},
        '{1'b0, 1'b1, 24'h0000FF, 24'h0000FF},
        '{1'b0, 1'b0, 24'h808080, 24'h000000},
        '{1'b0, 1'b0, 24'h7F7F7F, 24'h000000},
        '{1'b0, 1'b0, 24'h030201, 24'h000000},
        '{1'b0, 1'b0, 24'hFCFDFE, 24'h000000},
        '{1'b0, 1'b0, 24'h000000, 24'h000000},
        '{1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF},
        '{1'b0, 1'b0, 24'h7F807F, 24'h000000},
        '{1'b0, 1'b0, 24'h404040, 24'h000000},
        '{1'b0, 1'b0, 24'hC0C0C0, 24'h000000},
        '{1'b0, 1'b0, 24'hFFFFFF, 24'h000000},
        '{1'b0, 1'b0, 24'h00FF80, 24'h000000}
    };

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [rgbfsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [rgbfsd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [rgbfsd_pkg::TDATA_W-1:0]    s_axis_tdata = '0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [rgbfsd_pkg::TDATA_W-1:0]    m_axis_tdata;

    t_rgb expected_pixels [$];
    int   fails = 0;
    int   items_sent = 0;
    int   rx_stall = 0;
    bit   pace_on = 1'b1;

    // Model state: settings as written, line errors and carried shares.
    logic [rgbfsd_pkg::STEP_W-1:0] quant_step [rgbfsd_pkg::NUM_CH];
    logic [rgbfsd_pkg::LW_W-1:0]   row_len;
    int                err_below [rgbfsd_pkg::NUM_CH][0:rgbfsd_pkg::MAX_WIDTH];
    int                carry_right [rgbfsd_pkg::NUM_CH];
    int                carry_diag [rgbfsd_pkg::NUM_CH];
    int                col;
    bit                first_row;

    rgb_floyd_steinberg_dither dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clip_err(input int v);
        int r;
        r = v;
        if (v > 524287) r = 524287;
        if (v < -524288) r = -524288;
        return r;
    endfunction

    // floor(v * k / 16)
    function automatic int frac16(input int v, input int k);
        return (v * k) >>> 4;
    endfunction

    function automatic t_rgb dither_pixel(input t_rgb px, input logic fs);
        int   w;
        int   x;
        int   stp;
        int   above;
        int   v;
        int   n;
        int   q;
        int   e;
        t_rgb res;
        w = (row_len == 0) ? 1 : ((row_len > rgbfsd_pkg::MAX_WIDTH) ? rgbfsd_pkg::MAX_WIDTH
                                                                     : int'(row_len));
        if (fs) begin
            col = 0;
            first_row = 1'b1;
            for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
                carry_right[c] = 0;
                carry_diag[c] = 0;
            end
        end
        x = (col >= rgbfsd_pkg::MAX_WIDTH) ? rgbfsd_pkg::MAX_WIDTH - 1 : col;
        for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
            stp = (quant_step[c] == 0) ? 1 : int'(quant_step[c]);
            above = first_row ? 0 : err_below[c][x];
            v = int'(px[rgbfsd_pkg::PIX_W*c +: rgbfsd_pkg::PIX_W]) * 256 + carry_right[c]
                + above;
            if (v >= 0) begin
                n = (v + stp * 128) / (stp * 256);
            end else begin
                n = -((stp * 128 - v) / (stp * 256));
            end
            q = n * stp;
            e = clip_err(v - q * 256);
            res[rgbfsd_pkg::PIX_W*c +: rgbfsd_pkg::PIX_W] =
                (q < 0) ? 8'd0 : ((q > 255) ? 8'd255 : 8'(q));
            carry_right[c] = clip_err(frac16(e, 7));
            err_below[c][x] = clip_err(carry_diag[c] + frac16(e, 5));
            carry_diag[c] = clip_err(frac16(e, 1));
            if (x > 0) begin
                err_below[c][x-1] = clip_err(err_below[c][x-1] + frac16(e, 3));
            end
        end
        if (col + 1 >= w) begin
            col = 0;
            first_row = 1'b0;
            for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
                carry_right[c] = 0;
                carry_diag[c] = 0;
            end
        end else begin
            col = x + 1;
        end
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_pixel(input t_rgb px, input logic fs, input logic known,
                              input t_rgb want);
        t_rgb pred;
        if (pace_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tdata  <= px;
        s_axis_tuser  <= fs;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = dither_pixel(px, fs);
        expected_pixels.push_back(known ? want : pred);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input bit fresh);
        t_rgb px;
        logic fs;
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(0, 7))
                0: px = '0;
                1: px = '1;
                default: px = 24'($urandom);
            endcase
            fs = (i == 0 && fresh) || ($urandom_range(0, 39) == 0);
            push_pixel(px, fs, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [rgbfsd_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= rgbfsd_pkg::CFG_DATA_W'(val);
        case (idx)
            rgbfsd_pkg::REG_STEP_RED:   quant_step[0] = val[rgbfsd_pkg::STEP_W-1:0];
            rgbfsd_pkg::REG_STEP_GREEN: quant_step[1] = val[rgbfsd_pkg::STEP_W-1:0];
            rgbfsd_pkg::REG_STEP_BLUE:  quant_step[2] = val[rgbfsd_pkg::STEP_W-1:0];
            rgbfsd_pkg::REG_LINE_WIDTH: row_len = val[rgbfsd_pkg::LW_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_config(input int unsigned r, input int unsigned g,
                                input int unsigned b, input int unsigned wdt,
                                input logic [3:0] mask);
        if (mask[0]) put_reg(rgbfsd_pkg::REG_STEP_RED, r);
        if (mask[1]) put_reg(rgbfsd_pkg::REG_STEP_GREEN, g);
        if (mask[2]) put_reg(rgbfsd_pkg::REG_STEP_BLUE, b);
        if (mask[3]) put_reg(rgbfsd_pkg::REG_LINE_WIDTH, wdt);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int unsigned pick_step();
        int unsigned s;
        case ($urandom_range(0, 5))
            0: s = 1;
            1: s = 255;
            2: s = 0;
            3: s = $urandom_range(2, 16);
            default: s = $urandom_range(1, 255);
        endcase
        return s;
    endfunction

    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (pace_on && $urandom_range(0, 4) == 0) begin
            rx_stall <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_rgb want;
        t_rgb got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_pixels.size() == 0) begin
                $display("%0t: expected no result, got %h", $time, got);
                fails++;
            end else begin
                want = expected_pixels.pop_front();
                for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
                    if (got[rgbfsd_pkg::PIX_W*c +: rgbfsd_pkg::PIX_W]
                        !== want[rgbfsd_pkg::PIX_W*c +: rgbfsd_pkg::PIX_W]) begin
                        $display("%0t: channel %0d expected %0d, got %0d", $time, c,
                                 want[rgbfsd_pkg::PIX_W*c +: rgbfsd_pkg::PIX_W],
                                 got[rgbfsd_pkg::PIX_W*c +: rgbfsd_pkg::PIX_W]);
                        fails++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        for (int c = 0; c < rgbfsd_pkg::NUM_CH; c++) begin
            quant_step[c] = rgbfsd_pkg::STEP_RESET;
            carry_right[c] = 0;
            carry_diag[c] = 0;
            for (int k = 0; k <= rgbfsd_pkg::MAX_WIDTH; k++) err_below[c][k] = 0;
        end
        row_len = rgbfsd_pkg::WIDTH_RESET;
        col = 0;
        first_row = 1'b1;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < PLAN_N; i++) begin
            push_pixel(PLAN[i].px, PLAN[i].fs, PLAN[i].known, PLAN[i].want);
        end
        s_axis_tvalid <= 1'b0;

        // Settings sweep: smallest and largest steps and widths, a zero step,
        // widths out of range and a row shortened while it is under way.
        drain();
        apply_config(1, 1, 1, 1, 4'hF);
        run_phase(30, 1'b1);
        drain();
        apply_config(255, 0, 128, 0, 4'hF);
        run_phase(30, 1'b1);
        drain();
        apply_config(0, 0, 0, 4095, 4'hF);
        run_phase(40, 1'b1);
        drain();
        apply_config(255, 255, 255, 2048, 4'hF);
        run_phase(40, 1'b1);
        drain();
        apply_config(7, 16, 51, 8, 4'hF);
        run_phase(13, 1'b1);
        drain();
        apply_config(0, 0, 0, 3, 4'b1000);
        run_phase(20, 1'b0);

        while (items_sent < RANDOM_ITEMS) begin
            drain();
            pace_on = ($urandom_range(0, 3) != 0);
            apply_config(pick_step(), pick_step(), pick_step(),
                         ($urandom_range(0, 19) < 17) ? $urandom_range(1, 12)
                                                      : $urandom_range(0, 4095),
                         4'($urandom));
            run_phase($urandom_range(15, 50), $urandom_range(0, 1));
        end

        drain();
        pace_on = 1'b0;
        apply_config(pick_step(), pick_step(), pick_step(), $urandom_range(2, 9), 4'hF);
        run_phase(60, 1'b1);

        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
